>>> hw/rtl/blit_rect_clip_address_defines.svh
// ----------------------------------------------------------------------------
// Blit rectangle clip assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef BLIT_RECT_CLIP_ADDRESS_DEFINES_SVH
`define BLIT_RECT_CLIP_ADDRESS_DEFINES_SVH

// check a condition on every clock edge
`define BRCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check a consequence in the same cycle
`define BRCA_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// check a consequence in the next cycle
`define BRCA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/brca_pkg.sv
// ----------------------------------------------------------------------------
// Blit rectangle clip package
// Widths, codes and word types shared by the blit clip block and its channels.
// ----------------------------------------------------------------------------
package brca_pkg;

  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned DIM_W      = $clog2(MAX_DIM) + 1;
  localparam int unsigned COORD_W    = $clog2(MAX_DIM);
  localparam int unsigned POS_W      = 16;
  localparam int unsigned SRC_W      = 16;
  localparam int unsigned OFS_W      = 32;
  localparam int unsigned CNT_W      = 2 * DIM_W - 1;
  localparam int unsigned PB_W       = 3;
  localparam int unsigned PITCH_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NO_IMAGE    = 2'd1,
    STATUS_PB_MISMATCH = 2'd2,
    STATUS_CLIPPED     = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH      = 3'd0,
    CFG_SCREEN_HEIGHT     = 3'd1,
    CFG_DEST_PITCH        = 3'd2,
    CFG_DEST_PIXEL_BYTES  = 3'd3,
    CFG_IMAGE_WIDTH       = 3'd4,
    CFG_IMAGE_PIXEL_BYTES = 3'd5,
    CFG_IMAGE_PRESENT     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [POS_W-1:0] dest_x;
    logic signed [POS_W-1:0] dest_y;
    logic [COORD_W-1:0]      source_x;
    logic [COORD_W-1:0]      source_y;
    logic [DIM_W-1:0]        rect_width;
    logic [DIM_W-1:0]        rect_height;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [SRC_W-1:0]   clip_source_x;
    logic [SRC_W-1:0]   clip_source_y;
    logic [COORD_W-1:0] clip_dest_x;
    logic [COORD_W-1:0] clip_dest_y;
    logic [DIM_W-1:0]   copy_width;
    logic [DIM_W-1:0]   copy_height;
    logic [OFS_W-1:0]   source_offset;
    logic [OFS_W-1:0]   dest_offset;
    logic [CNT_W-1:0]   pixel_count;
  } res_t;

endpackage

>>> hw/rtl/brca_req_if.sv
// ----------------------------------------------------------------------------
// Blit request channel
// Valid/ready channel carrying one blit request word.
// ----------------------------------------------------------------------------
interface brca_req_if;
  import brca_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/brca_res_if.sv
// ----------------------------------------------------------------------------
// Blit result channel
// Valid/ready channel carrying one clip and address result word.
// ----------------------------------------------------------------------------
interface brca_res_if;
  import brca_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/blit_rect_clip_address.sv
// ----------------------------------------------------------------------------
// Blit rectangle clip and address
// Clips a source rectangle against the screen and forms both byte offsets.
//
//   channel  dir  payload        handshake
//   req_i    in   req_t request  valid/ready
//   res_o    out  res_t result   valid/ready
//   cfg      in   idx/data       cfg_we_i, no back-pressure
//
// One word per cycle sustained while res_o is ready; a request passes through
// the request register and then the result register.
// Clipping, two pixel-byte multiplies and three multiplies of up to 16x16 sit
// between them.
// A stalled result holds in its register while one more request waits.
// Reset loads the screen defaults and marks no image loaded.
// ----------------------------------------------------------------------------
`include "blit_rect_clip_address_defines.svh"

module blit_rect_clip_address (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [brca_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [brca_pkg::CFG_DATA_W-1:0] cfg_data_i,
  brca_req_if.sink                        req_i,
  brca_res_if.source                      res_o
);
  import brca_pkg::*;

  typedef struct packed {
    logic               hit;
    logic [DIM_W-1:0]   d;
    logic [SRC_W-1:0]   s;
    logic [DIM_W-1:0]   len;
  } axis_t;

  function automatic axis_t clip_axis(logic signed [POS_W-1:0] d,
                                      logic [COORD_W-1:0] s,
                                      logic [DIM_W-1:0] len,
                                      logic [DIM_W-1:0] scr);
    logic signed [POS_W+1:0] ds;
    logic signed [POS_W+1:0] last;
    logic signed [POS_W+1:0] fin;
    logic signed [POS_W+1:0] lo;
    logic signed [POS_W+1:0] hi;
    logic signed [POS_W+1:0] neg;
    logic signed [POS_W+1:0] span;
    axis_t r;
    ds   = {{2{d[POS_W-1]}}, d};
    last = $signed({{(POS_W+2-DIM_W){1'b0}}, scr}) - 18'sd1;
    fin  = ds + $signed({{(POS_W+2-DIM_W){1'b0}}, len}) - 18'sd1;
    lo   = ds[POS_W+1] ? '0 : ds;
    hi   = (fin > last) ? last : fin;
    neg  = ds[POS_W+1] ? (18'sd0 - ds) : '0;
    span = hi - lo + 18'sd1;
    r.hit = !(ds > last) && !fin[POS_W+1];
    r.d   = lo[DIM_W-1:0];
    r.s   = {{(SRC_W-COORD_W){1'b0}}, s} + neg[SRC_W-1:0];
    r.len = span[DIM_W-1:0];
    return r;
  endfunction

  logic [DIM_W-1:0]   scr_w_q;
  logic [DIM_W-1:0]   scr_h_q;
  logic [PITCH_W-1:0] dst_pitch_q;
  logic [PB_W-1:0]    dst_pb_q;
  logic [DIM_W-1:0]   img_w_q;
  logic [PB_W-1:0]    img_pb_q;
  logic               img_present_q;
  logic [PITCH_W-1:0] src_pitch_q;

  logic               req_vld_q;
  req_t               req_q;
  logic               res_vld_q;
  res_t               res_q;
  res_t               res_d;
  logic               adv;
  axis_t              ax;
  axis_t              ay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q       <= 13'd640;
      scr_h_q       <= 13'd480;
      dst_pitch_q   <= 16'd2560;
      dst_pb_q      <= 3'd4;
      img_w_q       <= '0;
      img_pb_q      <= '0;
      img_present_q <= 1'b0;
      src_pitch_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SCREEN_WIDTH:     scr_w_q     <= cfg_data_i[DIM_W-1:0];
        CFG_SCREEN_HEIGHT:    scr_h_q     <= cfg_data_i[DIM_W-1:0];
        CFG_DEST_PITCH:       dst_pitch_q <= cfg_data_i[PITCH_W-1:0];
        CFG_DEST_PIXEL_BYTES: dst_pb_q    <= cfg_data_i[PB_W-1:0];
        CFG_IMAGE_WIDTH: begin
          img_w_q     <= cfg_data_i[DIM_W-1:0];
          src_pitch_q <= {3'b0, cfg_data_i[DIM_W-1:0]} * {13'b0, img_pb_q};
        end
        CFG_IMAGE_PIXEL_BYTES: begin
          img_pb_q    <= cfg_data_i[PB_W-1:0];
          src_pitch_q <= {3'b0, img_w_q} * {13'b0, cfg_data_i[PB_W-1:0]};
        end
        CFG_IMAGE_PRESENT:    img_present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign adv         = !res_vld_q || res_o.ready;
  assign req_i.ready = !req_vld_q || adv;

  always_comb begin
    ax    = clip_axis(req_q.dest_x, req_q.source_x, req_q.rect_width, scr_w_q);
    ay    = clip_axis(req_q.dest_y, req_q.source_y, req_q.rect_height, scr_h_q);
    res_d = '0;
    if (!img_present_q) begin
      res_d.status = STATUS_NO_IMAGE;
    end else if (dst_pb_q != img_pb_q) begin
      res_d.status = STATUS_PB_MISMATCH;
    end else if (!ax.hit || !ay.hit) begin
      res_d.status = STATUS_CLIPPED;
    end else begin
      res_d.status        = STATUS_OK;
      res_d.clip_source_x = ax.s;
      res_d.clip_source_y = ay.s;
      res_d.clip_dest_x   = ax.d[COORD_W-1:0];
      res_d.clip_dest_y   = ay.d[COORD_W-1:0];
      res_d.copy_width    = ax.len;
      res_d.copy_height   = ay.len;
      res_d.source_offset = {16'b0, ax.s} * {29'b0, img_pb_q}
                          + {16'b0, ay.s} * {16'b0, src_pitch_q};
      res_d.dest_offset   = {19'b0, ax.d} * {29'b0, dst_pb_q}
                          + {19'b0, ay.d} * {16'b0, dst_pitch_q};
      res_d.pixel_count   = CNT_W'({13'b0, ax.len} * {13'b0, ay.len});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        req_vld_q <= req_i.valid;
      end
      if (adv) begin
        res_vld_q <= req_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= req_i.data;
    end
    if (adv && req_vld_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  `BRCA_ASSERT_NEXT(a_req_hold, req_vld_q && !adv, req_vld_q && $stable(req_q), "stalled request lost")
  `BRCA_ASSERT_IMPL(a_fail_zero, res_vld_q && res_q.status != STATUS_OK, res_q.pixel_count == '0 && res_q.copy_width == '0 && res_q.copy_height == '0, "failed result not zero")
  `BRCA_ASSERT_IMPL(a_count, res_vld_q && res_q.status == STATUS_OK, res_q.pixel_count == CNT_W'({12'b0, res_q.copy_width} * {12'b0, res_q.copy_height}), "pixel count mismatch")
  `BRCA_ASSERT_IMPL(a_on_screen, res_vld_q && res_q.status == STATUS_OK && res_q.copy_width != '0, {1'b0, res_q.clip_dest_x} < scr_w_q, "clipped corner off screen")

endmodule
